// ===== hdl/sfir_pkg.sv =====
// shared types and constants for the symmetric fir filter
package sfir_pkg;

    // fixed field widths
    localparam int COEFF_BITS   = 16;
    localparam int OUT_BITS     = 39;
    localparam int TAP_CNT_BITS = 7;
    localparam int CIDX_BITS    = 5;

    localparam logic [TAP_CNT_BITS-1:0] TAP_CNT_RESET = 7'd1;

    // transaction kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEFF  = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } seq_state_t;

    // control that travels alongside one tap pair through the pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic a_ok;
        logic b_ok;
    } tap_ctrl_t;

endpackage

// ===== hdl/sfir_hist_mem.sv =====
// sample history memory: one write port, two registered read ports
module sfir_hist_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16,
    parameter int AW    = 6
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [AW-1:0]           waddr,
    input  logic signed [WIDTH-1:0] wdata,
    input  logic [AW-1:0]           raddr_a,
    input  logic [AW-1:0]           raddr_b,
    output logic signed [WIDTH-1:0] rdata_a,
    output logic signed [WIDTH-1:0] rdata_b
);

    logic signed [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // two registered read ports
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== hdl/sfir_coef_mem.sv =====
// half-coefficient memory with per-entry valid bits so unwritten entries read as zero
module sfir_coef_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  we,
    input  logic [AW-1:0]                         waddr,
    input  logic signed [sfir_pkg::COEFF_BITS-1:0] wdata,
    input  logic [AW-1:0]                         raddr,
    output logic signed [sfir_pkg::COEFF_BITS-1:0] rdata,
    output logic                                  rvalid
);
    import sfir_pkg::*;

    logic signed [COEFF_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]             valid_reg;

    // storage write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

    // valid bits, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rvalid    <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid <= valid_reg[raddr];
        end
    end

endmodule

// ===== hdl/sfir_mac.sv =====
// pre-add, multiply and accumulate pipeline for one tap pair per cycle
module sfir_mac #(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_BITS    = 39
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sfir_pkg::tap_ctrl_t                   ctrl,
    input  logic signed [SAMPLE_BITS-1:0]         hist_a,
    input  logic signed [SAMPLE_BITS-1:0]         hist_b,
    input  logic signed [sfir_pkg::COEFF_BITS-1:0] coef,
    input  logic                                  coef_ok,
    output logic signed [ACC_BITS-1:0]            acc,
    output logic                                  done
);
    import sfir_pkg::*;

    localparam int PAIR_W = SAMPLE_BITS + 1;
    localparam int PROD_W = PAIR_W + COEFF_BITS;

    tap_ctrl_t                    ctrl1_reg, ctrl2_reg;
    logic signed [PAIR_W-1:0]     pair_reg, pair_next;
    logic signed [COEFF_BITS-1:0] coef_reg, coef_next;
    logic signed [PROD_W-1:0]     prod_reg, prod_next;
    logic signed [ACC_BITS-1:0]   acc_reg, acc_next;
    logic                         done_reg;
    logic signed [PAIR_W-1:0]     a_x, b_x;

    // pre-add of the mirrored samples, samples before the start read as zero
    always_comb
    begin
        a_x       = ctrl.a_ok ? PAIR_W'(hist_a) : '0;
        b_x       = ctrl.b_ok ? PAIR_W'(hist_b) : '0;
        pair_next = a_x + b_x;
        coef_next = coef_ok ? coef : '0;
    end

    // shared multiplier
    assign prod_next = pair_reg * coef_reg;

    // accumulator restarts on the first pair of a sample
    assign acc_next = (ctrl2_reg.first ? ACC_BITS'(0) : acc_reg) + ACC_BITS'(prod_reg);

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            ctrl1_reg <= ctrl;
            ctrl2_reg <= ctrl1_reg;
            done_reg  <= ctrl2_reg.valid && ctrl2_reg.last;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (ctrl.valid)
        begin
            pair_reg <= pair_next;
            coef_reg <= coef_next;
        end
        if (ctrl1_reg.valid)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

// ===== hdl/symmetric_fir_filter_top.sv =====
// top level of the folded symmetric fir filter with its sequencer
//
// Folded linear-phase FIR filter. A coefficient transaction (kind 1) writes
// one stored half-coefficient and gives no result. A sample transaction
// (kind 0) enters the history memory and is followed by one pre-add and
// multiply-accumulate per tap pair, plus one for the middle tap when the tap
// count N is odd, issued one per cycle from the history memory's two read
// ports through the single shared multiply-accumulate and its four-stage
// read/pre-add/multiply/accumulate pipeline; no new transaction is taken
// until the sample's result is in the output register. A finished result
// waits there while the next transaction is taken. History before reset or
// before a sample flagged first reads as zero through a fill count;
// coefficients not yet written read as zero. The user writes the tap count
// register through cfg_we/cfg_data only while the block is idle; the block
// does not enforce this. Values above MAX_TAPS are treated as MAX_TAPS.
module symmetric_fir_filter_top #(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic [sfir_pkg::TAP_CNT_BITS-1:0]        cfg_data,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic                                     kind,
    input  logic                                     first,
    input  logic signed [SAMPLE_BITS-1:0]            sample,
    input  logic [sfir_pkg::CIDX_BITS-1:0]           coeff_index,
    input  logic signed [sfir_pkg::COEFF_BITS-1:0]   coeff_value,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [sfir_pkg::OUT_BITS-1:0]     filtered
);
    import sfir_pkg::*;

    localparam int HALF_SLOTS = (MAX_TAPS + 1) / 2;
    localparam int A_W        = $clog2(MAX_TAPS);
    localparam int N_W        = $clog2(MAX_TAPS + 1);
    localparam int CA_W       = (HALF_SLOTS > 1) ? $clog2(HALF_SLOTS) : 1;
    localparam int CMP_W      = (N_W > TAP_CNT_BITS) ? N_W : TAP_CNT_BITS;
    localparam int IDX_W      = ((CA_W > CIDX_BITS) ? CA_W : CIDX_BITS) + 1;
    localparam int PROD_W     = SAMPLE_BITS + 1 + COEFF_BITS;
    localparam int SUM_W      = PROD_W + $clog2(HALF_SLOTS + 1);
    localparam int ACC_W      = (SUM_W > OUT_BITS) ? SUM_W : OUT_BITS;

    seq_state_t                  state_reg, state_next;
    logic [TAP_CNT_BITS-1:0]     tap_cfg_reg;
    logic [N_W-1:0]              n_reg, n_next;
    logic [N_W-1:0]              k_reg, k_next;
    logic [N_W-1:0]              fill_reg, fill_next;
    logic [A_W-1:0]              wp_reg, wp_next;
    logic                        zero_reg, zero_next;
    logic                        out_valid_reg, out_valid_next;
    logic signed [OUT_BITS-1:0]  filtered_reg;
    logic                        out_load;
    logic signed [OUT_BITS-1:0]  out_value;

    logic                        accept, accept_sample, accept_coeff;
    logic [CMP_W-1:0]            tap_ext;
    logic [N_W-1:0]              n_eff, half, steps, d_b;
    logic                        odd, mid;
    tap_ctrl_t                   issue_ctrl, ctrl_rd_reg;
    logic [A_W-1:0]              raddr_a, raddr_b;
    logic [IDX_W-1:0]            idx_ext;
    logic                        coef_we;

    logic signed [SAMPLE_BITS-1:0] hist_a, hist_b;
    logic signed [COEFF_BITS-1:0]  coef_rd;
    logic                          coef_ok;
    logic signed [ACC_W-1:0]       mac_acc;
    logic                          mac_done;

    // history position of a given delay, modulo the memory depth
    function automatic logic [A_W-1:0] hist_addr(input logic [A_W-1:0] wp,
                                                 input logic [N_W-1:0] d);
        logic [N_W:0] t;
        t = (N_W + 1)'(wp) + (N_W + 1)'(MAX_TAPS) - (N_W + 1)'(d);
        if (t >= (N_W + 1)'(MAX_TAPS))
        begin
            t = t - (N_W + 1)'(MAX_TAPS);
        end
        return t[A_W-1:0];
    endfunction

    // handshake and transaction decode
    assign in_ready      = (state_reg == S_IDLE);
    assign accept        = in_valid && in_ready;
    assign accept_sample = accept && (kind == KIND_SAMPLE);
    assign accept_coeff  = accept && (kind == KIND_COEFF);

    // effective tap count, saturated to the history depth
    always_comb
    begin
        tap_ext = CMP_W'(tap_cfg_reg);
        if (tap_ext > CMP_W'(MAX_TAPS))
        begin
            n_eff = N_W'(MAX_TAPS);
        end
        else
        begin
            n_eff = tap_ext[N_W-1:0];
        end
    end

    // coefficient write, indexes beyond the store are dropped
    assign idx_ext = IDX_W'(coeff_index);
    assign coef_we = accept_coeff && (idx_ext < IDX_W'(HALF_SLOTS));

    // tap pair issue from the step counter
    always_comb
    begin
        half  = n_reg >> 1;
        odd   = n_reg[0];
        steps = half + N_W'(odd);
        d_b   = n_reg - N_W'(1) - k_reg;
        mid   = odd && (k_reg == half);

        issue_ctrl.valid = (state_reg == S_RUN);
        issue_ctrl.first = (k_reg == '0);
        issue_ctrl.last  = ((k_reg + N_W'(1)) == steps);
        issue_ctrl.a_ok  = (k_reg < fill_reg);
        issue_ctrl.b_ok  = !mid && (d_b < fill_reg);

        raddr_a = hist_addr(wp_reg, k_reg);
        raddr_b = hist_addr(wp_reg, d_b);
    end

    // next history pointer and fill count for an accepted sample
    always_comb
    begin
        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (accept_sample)
        begin
            wp_next = (wp_reg == A_W'(MAX_TAPS - 1)) ? '0 : wp_reg + A_W'(1);
            if (first)
            begin
                fill_next = N_W'(1);
            end
            else if (fill_reg != N_W'(MAX_TAPS))
            begin
                fill_next = fill_reg + N_W'(1);
            end
        end
    end

    // result value for the output register
    assign out_value = zero_reg ? '0 : mac_acc[OUT_BITS-1:0];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        zero_next      = zero_reg;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept_sample)
                begin
                    n_next    = n_eff;
                    k_next    = '0;
                    zero_next = (n_eff == '0);
                    state_next = (n_eff == '0) ? S_DONE : S_RUN;
                end
            end
            S_RUN:
            begin
                k_next = k_reg + N_W'(1);
                if (issue_ctrl.last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (mac_done)
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_load       = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tap_cfg_reg   <= TAP_CNT_RESET;
            n_reg         <= '0;
            k_reg         <= '0;
            fill_reg      <= '0;
            wp_reg        <= '0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            ctrl_rd_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            fill_reg      <= fill_next;
            wp_reg        <= wp_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
            ctrl_rd_reg   <= issue_ctrl;
            if (cfg_we)
            begin
                tap_cfg_reg <= cfg_data;
            end
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            filtered_reg <= out_value;
        end
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

    sfir_hist_mem #(
        .DEPTH (MAX_TAPS),
        .WIDTH (SAMPLE_BITS),
        .AW    (A_W)
    ) u_hist (
        .clk     (clk),
        .we      (accept_sample),
        .waddr   (wp_next),
        .wdata   (sample),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (hist_a),
        .rdata_b (hist_b)
    );

    sfir_coef_mem #(
        .DEPTH (HALF_SLOTS),
        .AW    (CA_W)
    ) u_coef (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (coef_we),
        .waddr  (idx_ext[CA_W-1:0]),
        .wdata  (coeff_value),
        .raddr  (k_reg[CA_W-1:0]),
        .rdata  (coef_rd),
        .rvalid (coef_ok)
    );

    sfir_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_BITS    (ACC_W)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl_rd_reg),
        .hist_a  (hist_a),
        .hist_b  (hist_b),
        .coef    (coef_rd),
        .coef_ok (coef_ok),
        .acc     (mac_acc),
        .done    (mac_done)
    );

endmodule

// ===== hdl/sfir_port_checker.sv =====
// port-level checks for the symmetric fir filter, bound to the top level
module sfir_port_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 kind,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [sfir_pkg::OUT_BITS-1:0] filtered
);
    import sfir_pkg::*;

    // an offered transaction stays offered until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
    else $error("input valid dropped before acceptance");

    // a stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(filtered))
    else $error("result changed or vanished while stalled");

    // a sample keeps the block busy for at least the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_SAMPLE) |=> !in_ready)
    else $error("block ready straight after a sample");

    // the block is ready again in the cycle after a coefficient write
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_COEFF) |=> in_ready)
    else $error("block busy after a coefficient write");

endmodule

bind symmetric_fir_filter_top sfir_port_checker u_port_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .filtered  (filtered)
);

// ===== tb/sfir_checker.sv =====
// transaction monitor, folded fir predictor and result comparator
module sfir_checker #(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic [sfir_pkg::TAP_CNT_BITS-1:0]        cfg_data,
    input  logic                                     in_valid,
    input  logic                                     in_ready,
    input  logic                                     kind,
    input  logic                                     first,
    input  logic signed [SAMPLE_BITS-1:0]            sample,
    input  logic [sfir_pkg::CIDX_BITS-1:0]           coeff_index,
    input  logic signed [sfir_pkg::COEFF_BITS-1:0]   coeff_value,
    input  logic                                     out_valid,
    input  logic                                     out_ready,
    input  logic signed [sfir_pkg::OUT_BITS-1:0]     filtered,
    output int                                       errors,
    output int                                       outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    import sfir_pkg::*;

    localparam int HALF_SLOTS = (MAX_TAPS + 1) / 2;

    // shadow copy of the filter state
    logic signed [SAMPLE_BITS-1:0] hist [MAX_TAPS];
    logic signed [COEFF_BITS-1:0]  half_coef [HALF_SLOTS];
    logic [TAP_CNT_BITS-1:0]       taps_cfg;

    // filter outputs still owed by the block, oldest first
    logic signed [OUT_BITS-1:0]    expected_filtered [$];

    // folded sum over mirrored pairs plus the middle tap for odd lengths
    function automatic logic signed [OUT_BITS-1:0] folded_fir_sum();
        int     n;
        int     half;
        longint acc;
        longint pair;
        n    = (int'(taps_cfg) > MAX_TAPS) ? MAX_TAPS : int'(taps_cfg);
        half = n / 2;
        acc  = 0;
        for (int k = 0; k < half; k++)
        begin
            pair = longint'(hist[k]) + longint'(hist[n - 1 - k]);
            acc += pair * longint'(half_coef[k]);
        end
        if ((n % 2) != 0)
        begin
            acc += longint'(hist[half]) * longint'(half_coef[half]);
        end
        return acc[OUT_BITS-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [OUT_BITS-1:0] want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                hist[i] = '0;
            end
            for (int i = 0; i < HALF_SLOTS; i++)
            begin
                half_coef[i] = '0;
            end
            taps_cfg = TAP_CNT_RESET;
            expected_filtered.delete();
            errors      = 0;
            outstanding = 0;
        end
        else
        begin
            // result transaction against the oldest expectation
            if (out_valid && out_ready)
            begin
                if (expected_filtered.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual filtered %0d",
                             $time, filtered);
                    errors++;
                end
                else
                begin
                    want = expected_filtered.pop_front();
                    if (filtered !== want)
                    begin
                        $display("%0t: filtered mismatch, expected %0d, actual %0d",
                                 $time, want, filtered);
                        errors++;
                    end
                end
            end

            // input transaction: coefficient write or new sample
            if (in_valid && in_ready)
            begin
                if (kind == KIND_COEFF)
                begin
                    if (int'(coeff_index) < HALF_SLOTS)
                    begin
                        half_coef[coeff_index] = coeff_value;
                    end
                end
                else
                begin
                    if (first)
                    begin
                        for (int i = 0; i < MAX_TAPS; i++)
                        begin
                            hist[i] = '0;
                        end
                    end
                    for (int i = MAX_TAPS - 1; i > 0; i--)
                    begin
                        hist[i] = hist[i - 1];
                    end
                    hist[0] = sample;
                    expected_filtered.push_back(folded_fir_sum());
                end
            end

            // tap count register, seen by the block from the next transaction on
            if (cfg_we)
            begin
                taps_cfg = cfg_data;
            end

            outstanding = expected_filtered.size();
        end
    end

endmodule

// ===== tb/tb_symmetric_fir_filter_top.sv =====
// stimulus, handshake pacing and verdict for the symmetric fir filter
module tb_symmetric_fir_filter_top;

    timeunit 1ns;
    timeprecision 1ps;

    import sfir_pkg::*;

    localparam int MAX_TAPS       = 64;
    localparam int SAMPLE_BITS    = 16;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_ITEMS    = 28;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [TAP_CNT_BITS-1:0]        cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    logic                           kind;
    logic                           first;
    logic signed [SAMPLE_BITS-1:0]  sample;
    logic [CIDX_BITS-1:0]           coeff_index;
    logic signed [COEFF_BITS-1:0]   coeff_value;
    logic                           out_valid;
    logic                           out_ready;
    logic signed [OUT_BITS-1:0]     filtered;

    int errors;
    int outstanding;
    bit src_idle_en;
    bit sink_idle_en;

    // tap count schedule for the random phases
    logic [TAP_CNT_BITS-1:0] phase_taps [13] = '{
        7'd64, 7'd127, 7'd0, 7'd2, 7'd3, 7'd63, 7'd65, 7'd33,
        7'd17, 7'd48, 7'd1, 7'd64, 7'd64
    };

    symmetric_fir_filter_top #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .first       (first),
        .sample      (sample),
        .coeff_index (coeff_index),
        .coeff_value (coeff_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .filtered    (filtered)
    );

    sfir_checker #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .first       (first),
        .sample      (sample),
        .coeff_index (coeff_index),
        .coeff_value (coeff_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .filtered    (filtered),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // q1.15 value, biased towards the extremes
    function automatic logic signed [15:0] rand_q15(bit extreme);
        if (extreme)
        begin
            return ($urandom_range(0, 3) == 0) ? 16'sh7fff : 16'sh8000;
        end
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // one input transaction; entered and left at a falling edge
    task automatic send_txn(logic k, logic f, logic signed [15:0] s,
                            logic [CIDX_BITS-1:0] idx, logic signed [15:0] v);
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        first       <= f;
        sample      <= s;
        coeff_index <= idx;
        coeff_value <= v;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_sample(logic f, logic signed [15:0] s);
        send_txn(KIND_SAMPLE, f, s, CIDX_BITS'($urandom), 16'($urandom));
    endtask

    task automatic send_coeff(logic [CIDX_BITS-1:0] idx, logic signed [15:0] v);
        send_txn(KIND_COEFF, 1'($urandom), 16'($urandom), idx, v);
    endtask

    // hold the sender off until every owed result has arrived
    task automatic drain_results();
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    // tap count write, only once the block has gone quiet
    task automatic write_taps(logic [TAP_CNT_BITS-1:0] n);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= n;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // mostly samples, some coefficient writes, occasional restarts
    task automatic random_txn(bit extreme);
        if ($urandom_range(0, 99) < 20)
        begin
            send_coeff(CIDX_BITS'($urandom), rand_q15(extreme));
        end
        else
        begin
            send_sample(($urandom_range(0, 19) == 0), rand_q15(extreme));
        end
    endtask

    // result side backpressure
    initial
    begin
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (sink_idle_en && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no transaction at all
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_symmetric_fir_filter_top: FAIL");
        $finish;
    end

    // main sequence
    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        kind         = KIND_SAMPLE;
        first        = 1'b0;
        sample       = '0;
        coeff_index  = '0;
        coeff_value  = '0;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset tap count, empty coefficients, extremes
        send_sample(1'b1, 16'sh7fff);
        send_coeff(5'd0, 16'sh7fff);
        send_txn(KIND_COEFF, 1'b1, 16'sh0000, 5'd31, 16'sh8000);
        send_sample(1'b0, 16'sh8000);
        send_sample(1'b0, 16'sh7fff);

        // directed: odd length with a middle tap
        write_taps(7'd3);
        send_coeff(5'd1, 16'sh8000);
        send_sample(1'b1, 16'sh0001);
        send_sample(1'b0, 16'sh8000);
        send_sample(1'b0, 16'sh7fff);
        send_sample(1'b0, 16'sh0000);

        // directed: zero taps give zero
        write_taps(7'd0);
        send_sample(1'b0, 16'sh3039);

        // directed: tap count above the maximum saturates
        write_taps(7'd127);
        send_sample(1'b1, 16'sh8000);
        send_sample(1'b0, 16'sh8000);

        // directed: even length, largest pair product
        write_taps(7'd2);
        send_sample(1'b1, 16'sh7fff);
        send_sample(1'b0, 16'sh8000);
        send_coeff(5'd0, 16'sh8000);
        send_sample(1'b0, 16'sh8000);
        send_sample(1'b0, 16'sh8000);

        // sender holds off until everything has come back
        drain_results();
        @(negedge clk);

        // random phases over the tap schedule
        for (int p = 0; p < $size(phase_taps); p++)
        begin
            bit extreme;
            extreme = (p == 11);
            if (p == $size(phase_taps) - 1)
            begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end
            write_taps(phase_taps[p]);
            // full-scale coefficient set for the worst-case sum
            if (extreme)
            begin
                for (int i = 0; i < 32; i++)
                begin
                    send_coeff(CIDX_BITS'(i), 16'sh8000);
                end
                send_sample(1'b1, 16'sh8000);
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                random_txn(extreme);
            end
        end

        // wait out the tail and give the verdict
        drain_results();
        repeat (SETTLE_CYCLES + 20) @(negedge clk);
        if (errors == 0 && outstanding == 0)
            $display("tb_symmetric_fir_filter_top: PASS");
        else
            $display("tb_symmetric_fir_filter_top: FAIL");
        $finish;
    end

endmodule

// ===== symmetric_fir_filter_top.f =====
hdl/sfir_pkg.sv
hdl/sfir_hist_mem.sv
hdl/sfir_coef_mem.sv
hdl/sfir_mac.sv
hdl/symmetric_fir_filter_top.sv
hdl/sfir_port_checker.sv
tb/sfir_checker.sv
tb/tb_symmetric_fir_filter_top.sv
